### rtl/hssd_pkg.sv
// Shared types and constants for the header sync / sum16 deframer.
// Holds the fixed sync header bytes and the field widths of the byte stream.
// No dependencies.
package hssd_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 7;
  localparam int SUM_W  = 16;
  localparam int HDR_BYTES = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SUM_W-1:0]  sum_t;

  localparam byte_t SYNC_BYTE_1 = 8'hCE;
  localparam byte_t SYNC_BYTE_2 = 8'h3A;
  localparam byte_t SYNC_BYTE_3 = 8'h55;
  localparam byte_t SYNC_BYTE_0_RESET = 8'hAA;

  // Header position codes, taken from the low bits of the frame counter
  localparam logic [1:0] HDR_POS_0 = 2'd0;
  localparam logic [1:0] HDR_POS_1 = 2'd1;
  localparam logic [1:0] HDR_POS_2 = 2'd2;
  localparam logic [1:0] HDR_POS_3 = 2'd3;

endpackage

### rtl/header_sync_sum16_deframer_unit.sv
// Top level of the header sync / sum16 deframer: hunt, frame count, checksum.
// Depends on hssd_pkg for the header bytes and field types.
//
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) carries one received byte per
//   transaction. The block hunts for the header {first sync byte, 0xCE, 0x3A,
//   0x55}; a mismatch drops all header bytes seen so far, the mismatching one
//   included. Header bytes give no result. Each later frame byte leaves on the
//   output channel with its position (modulo 128); the last byte of the
//   FRAME_BYTES-long frame carries frame_end and the 16-bit sum verdict.
//   Path: the byte lands in the input register at its input transaction,
//   then its result is loaded into the result register, which drives
//   out_valid. Throughput: one byte per cycle while the receiver does not
//   stall, set by the combinational compare/add/count step.
//   Receiver stall: the result register holds; one more byte is taken into
//   the input register, and header bytes keep draining since they make no
//   result. Input then stalls until the result is taken.
//   Reset (rst_n low, synchronous): both registers empty, hunting restarts at
//   header byte zero, first sync byte returns to 0xAA.
//   cfg_wr_en/cfg_wr_data write the first sync byte; write it while idle.
module header_sync_sum16_deframer_unit
  import hssd_pkg::*;
#(
  parameter int FRAME_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic [6:0]  out_frame_position,
  output logic        out_frame_end,
  output logic        out_sum_matches
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] CSUM_LO_POS = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] HDR_END = CNT_W'(HDR_BYTES);

  byte_t            sync0_r;
  logic             in_valid_r;
  byte_t            in_byte_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sum_t             sum_r, sum_nxt;
  byte_t            sum_lo_r, sum_lo_nxt;
  logic             out_valid_r;
  byte_t            out_byte_r;
  pos_t             out_pos_r;
  logic             out_end_r;
  logic             out_match_r;

  logic             in_header;
  logic             is_last;
  byte_t            hdr_expect;
  logic             emit;
  logic             adv;
  logic [CNT_W+POS_W-1:0] cnt_ext;
  pos_t             cur_pos;
  logic             match_now;

  always_comb begin
    case (cnt_r[1:0])
      HDR_POS_0: hdr_expect = sync0_r;
      HDR_POS_1: hdr_expect = SYNC_BYTE_1;
      HDR_POS_2: hdr_expect = SYNC_BYTE_2;
      HDR_POS_3: hdr_expect = SYNC_BYTE_3;
      default:   hdr_expect = SYNC_BYTE_3;
    endcase
  end

  assign in_header = (cnt_r < HDR_END);
  assign is_last   = (cnt_r == LAST_POS);
  assign emit      = in_valid_r && !in_header;
  // header bytes never wait on the result register
  assign adv       = in_valid_r && (in_header || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign cnt_ext   = {{POS_W{1'b0}}, cnt_r};
  assign cur_pos   = cnt_ext[POS_W-1:0];
  assign match_now = ({in_byte_r, sum_lo_r} == sum_r);

  always_comb begin
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    sum_lo_nxt = sum_lo_r;
    if (in_header) begin
      if (in_byte_r == hdr_expect) begin
        cnt_nxt = cnt_r + 1'b1;
        sum_nxt = sum_r + SUM_W'(in_byte_r);
      end else begin
        // drop the partial header and hunt again
        cnt_nxt    = '0;
        sum_nxt    = '0;
        sum_lo_nxt = '0;
      end
    end else if (is_last) begin
      cnt_nxt    = '0;
      sum_nxt    = '0;
      sum_lo_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r < CSUM_LO_POS) begin
        sum_nxt = sum_r + SUM_W'(in_byte_r);
      end else begin
        sum_lo_nxt = in_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync0_r     <= SYNC_BYTE_0_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      sum_lo_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        sync0_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        cnt_r    <= cnt_nxt;
        sum_r    <= sum_nxt;
        sum_lo_r <= sum_lo_nxt;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && emit) begin
      out_byte_r  <= in_byte_r;
      out_pos_r   <= cur_pos;
      out_end_r   <= is_last;
      out_match_r <= is_last && match_now;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_byte     = out_byte_r;
  assign out_frame_position = out_pos_r;
  assign out_frame_end      = out_end_r;
  assign out_sum_matches    = out_match_r;

`ifndef ASSERT_OFF
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_POS)
    else $error("frame counter beyond last position");

  a_match_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_end_r |-> !out_match_r)
    else $error("sum verdict on a byte that does not end the frame");

  a_no_hold_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |-> adv)
    else $error("buffered byte held while result register is free");

  a_hunt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit && is_last |=> cnt_r == '0)
    else $error("hunt did not restart after frame end");
`endif

endmodule

### test/tb_header_sync_sum16_deframer_unit.sv
// Testbench for header_sync_sum16_deframer_unit: directed and random byte streams
// checked against an in-bench deframer model, with random idle and stall on both sides.
// Depends on hssd_pkg and the deframer RTL.
module tb_header_sync_sum16_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hssd_pkg::*;

  localparam int FRAME_BYTES  = 128;
  localparam int RANDOM_ITEMS = 230;
  localparam int EXP_DEPTH    = 16;

  typedef struct {
    byte_t data;
    pos_t  pos;
    logic  last;
    logic  good;
  } frame_out_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_frame_byte;
  logic [6:0] out_frame_position;
  logic       out_frame_end;
  logic       out_sum_matches;

  // deframer model state
  int unsigned frame_count;
  sum_t        frame_sum;
  byte_t       sum_lo_seen;
  byte_t       sync0_now;

  // expected results, oldest at exp_rd
  frame_out_t  exp_fifo[EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  byte_t       frame_buf[FRAME_BYTES];
  int          bytes_sent;
  int          mismatches;
  bit          quiet;

  header_sync_sum16_deframer_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_frame_position(out_frame_position),
    .out_frame_end     (out_frame_end),
    .out_sum_matches   (out_sum_matches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic byte_t header_byte_at(int unsigned idx);
    logic [1:0] sel;
    sel = idx[1:0];
    case (sel)
      HDR_POS_0: return sync0_now;
      HDR_POS_1: return SYNC_BYTE_1;
      HDR_POS_2: return SYNC_BYTE_2;
      default:   return SYNC_BYTE_3;
    endcase
  endfunction

  task automatic store_expected(input frame_out_t r);
    exp_fifo[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endtask

  function automatic frame_out_t next_expected();
    frame_out_t r;
    r = exp_fifo[exp_rd % EXP_DEPTH];
    exp_rd++;
    return r;
  endfunction

  task automatic restart_hunt();
    frame_count = 0;
    frame_sum   = '0;
    sum_lo_seen = '0;
  endtask

  // Advance the model by one accepted byte; queue the result it produces, if any.
  task automatic deframe_byte(input byte_t b);
    frame_out_t r;
    if (frame_count < HDR_BYTES) begin
      if (b == header_byte_at(frame_count)) begin
        frame_sum = frame_sum + sum_t'(b);
        frame_count++;
      end else begin
        restart_hunt();
      end
    end else begin
      r.data = b;
      r.pos  = frame_count[POS_W-1:0];
      r.last = (frame_count >= FRAME_BYTES - 1);
      r.good = 1'b0;
      if (r.last) begin
        r.good = ({b, sum_lo_seen} == frame_sum);
        restart_hunt();
      end else begin
        if (frame_count < FRAME_BYTES - 2) frame_sum = frame_sum + sum_t'(b);
        else sum_lo_seen = b;
        frame_count++;
      end
      store_expected(r);
    end
  endtask

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_rx_byte(input byte_t b);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    // header bytes still in the pipeline produce no result
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sync_byte(input byte_t v);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sync0_now   = v;
  endtask

  // fill < 0: random payload; flip_at >= 0: corrupt one bit of that byte
  task automatic build_frame(input int fill, input int flip_at);
    sum_t s;
    s = '0;
    frame_buf[0] = sync0_now;
    frame_buf[1] = SYNC_BYTE_1;
    frame_buf[2] = SYNC_BYTE_2;
    frame_buf[3] = SYNC_BYTE_3;
    for (int i = HDR_BYTES; i < FRAME_BYTES - 2; i++)
      frame_buf[i] = (fill < 0) ? byte_t'($urandom) : byte_t'(fill);
    for (int i = 0; i < FRAME_BYTES - 2; i++) s = s + sum_t'(frame_buf[i]);
    frame_buf[FRAME_BYTES-2] = s[7:0];
    frame_buf[FRAME_BYTES-1] = s[15:8];
    if (flip_at >= 0) frame_buf[flip_at] ^= byte_t'(1 << $urandom_range(7));
  endtask

  task automatic send_span(input int lo, input int hi);
    for (int i = lo; i < hi; i++) send_rx_byte(frame_buf[i]);
  endtask

  task automatic send_frame(input int fill, input int flip_at);
    build_frame(fill, flip_at);
    send_span(0, FRAME_BYTES);
  endtask

  task automatic test_header_hunt();
    byte_t hunt_seq[$] = '{8'h00, 8'hFF,
                           SYNC_BYTE_0_RESET, 8'h00,
                           SYNC_BYTE_0_RESET, SYNC_BYTE_1, 8'hFF,
                           SYNC_BYTE_0_RESET, SYNC_BYTE_1, SYNC_BYTE_2, SYNC_BYTE_0_RESET,
                           SYNC_BYTE_0_RESET, SYNC_BYTE_0_RESET, SYNC_BYTE_1, SYNC_BYTE_2,
                           SYNC_BYTE_3};
    foreach (hunt_seq[i]) send_rx_byte(hunt_seq[i]);
    wait_idle();
  endtask

  task automatic test_good_frames();
    send_frame(-1, -1);
    send_frame(8'h00, -1);
    send_frame(8'hFF, -1);
    wait_idle();
  endtask

  task automatic test_bad_frames();
    send_frame(-1, FRAME_BYTES - 2);
    send_frame(-1, FRAME_BYTES - 1);
    send_frame(-1, 20);
    wait_idle();
  endtask

  task automatic test_sync_byte_config();
    write_sync_byte(8'h00);
    send_frame(-1, -1);
    write_sync_byte(8'hFF);
    send_frame(-1, -1);
    write_sync_byte(SYNC_BYTE_1);
    send_frame(-1, -1);
    // new first sync byte lands mid-frame: the frame in progress must still pass
    build_frame(-1, -1);
    send_span(0, 60);
    write_sync_byte(8'h5A);
    send_span(60, FRAME_BYTES);
    send_frame(-1, -1);
    write_sync_byte(SYNC_BYTE_0_RESET);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int n;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      quiet = (bytes_sent - start >= 20) && (bytes_sent - start < 170);
      pick  = $urandom_range(99);
      if (pick < 5) begin
        case ($urandom_range(3))
          0:       write_sync_byte(8'h00);
          1:       write_sync_byte(8'hFF);
          default: write_sync_byte(byte_t'($urandom));
        endcase
      end else if (pick < 65) begin
        send_frame(-1, -1);
      end else if (pick < 78) begin
        send_frame(-1, $urandom_range(FRAME_BYTES - 1));
      end else if (pick < 86) begin
        // truncated frame: once its header is complete, following bytes get absorbed into it
        build_frame(-1, -1);
        send_span(0, $urandom_range(1, FRAME_BYTES - 1));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          case ($urandom_range(4))
            0:       send_rx_byte(sync0_now);
            1:       send_rx_byte(SYNC_BYTE_1);
            2:       send_rx_byte(SYNC_BYTE_2);
            3:       send_rx_byte(SYNC_BYTE_3);
            default: send_rx_byte(byte_t'($urandom));
          endcase
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = quiet || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    frame_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %h pos %0d end %b sum_ok %b",
                   out_frame_byte, out_frame_position, out_frame_end, out_sum_matches);
      end else begin
        want = next_expected();
        if (out_frame_byte !== want.data || out_frame_position !== want.pos ||
            out_frame_end !== want.last || out_sum_matches !== want.good) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result differs: expected byte %h pos %0d end %b sum_ok %b,",
                      " got byte %h pos %0d end %b sum_ok %b"},
                     want.data, want.pos, want.last, want.good,
                     out_frame_byte, out_frame_position, out_frame_end, out_sum_matches);
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    quiet       = 1'b0;
    bytes_sent  = 0;
    mismatches  = 0;
    exp_wr      = 0;
    exp_rd      = 0;
    sync0_now   = SYNC_BYTE_0_RESET;
    restart_hunt();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_header_hunt();
    test_good_frames();
    test_bad_frames();
    test_sync_byte_config();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### header_sync_sum16_deframer_unit.f
rtl/hssd_pkg.sv
rtl/header_sync_sum16_deframer_unit.sv
test/tb_header_sync_sum16_deframer_unit.sv
